>>> hdl/gbnrc_pkg.sv
// Shared types and codes for the go-back-n receiver check block.
package gbnrc_pkg;

  localparam int unsigned SEQ_W  = 8;
  localparam int unsigned TYPE_W = 8;
  localparam int unsigned CSUM_W = 16;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [2:0] {
    ACT_ACCEPT = 3'd0,
    ACT_DUP    = 3'd1,
    ACT_FIN    = 3'd2,
    ACT_RESET  = 3'd3,
    ACT_DROP   = 3'd4,
    ACT_CLOSED = 3'd5
  } action_t;

  typedef enum logic {
    REQ_HEADER  = 1'b0,
    REQ_PAYLOAD = 1'b1
  } req_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DATA_TYPE = 2'd0,
    CFG_FIN_TYPE  = 2'd1,
    CFG_SYN_TYPE  = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_index_t;

  // Header view of the packet that ends with the current request
  typedef struct packed {
    logic [TYPE_W-1:0] pkt_type;
    logic [SEQ_W-1:0]  seq;
    logic              checksum_ok;
  } hdr_view_t;

endpackage

>>> hdl/go_back_n_receiver_check.sv
// Top level of the go-back-n receiver verdict engine.
//
//   channel | direction | handshake          | payload
//   in_     | in        | in_valid/in_stall  | req_type pkt_type rx_seq rx_checksum data_word
//           |           |                    | last_word
//   out_    | out       | out_valid/out_stall| action ack_seq checksum_ok
//   cfg_    | in        | cfg_we             | cfg_index cfg_wdata
//
// One request per cycle while in_stall is low; a last request's verdict is registered.
// Checksum add, fold and compare sit between the request and the result register.
// A skid register holds a second verdict; in_stall rises only when it is full.
// Synchronous reset: link open, expected sequence zero, type codes 2, 4 and 0.
module go_back_n_receiver_check_core import gbnrc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [TYPE_W-1:0]    in_pkt_type,
  input  logic [SEQ_W-1:0]     in_rx_seq,
  input  logic [CSUM_W-1:0]    in_rx_checksum,
  input  logic [CSUM_W-1:0]    in_data_word,
  input  logic                 in_last_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [2:0]           out_action,
  output logic [SEQ_W-1:0]     out_ack_seq,
  output logic                 out_checksum_ok,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [TYPE_W-1:0] data_code_r, fin_code_r, syn_code_r;
  logic [SEQ_W-1:0]  exp_seq_r, exp_seq_nxt;
  logic              link_open_r, link_open_nxt;
  logic              in_accept;
  logic              fire;
  hdr_view_t         view;
  action_t           res_action;
  logic [SEQ_W-1:0]  res_ack;

  action_t           out_action_r, skid_action_r;
  logic [SEQ_W-1:0]  out_ack_r, skid_ack_r;
  logic              out_ok_r, skid_ok_r;
  logic              out_valid_r, skid_valid_r;
  logic              drain;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign fire      = in_accept && in_last_word;

  gbnrc_acc u_acc (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .req_type    (in_req_type),
    .pkt_type    (in_pkt_type),
    .rx_seq      (in_rx_seq),
    .rx_checksum (in_rx_checksum),
    .data_word   (in_data_word),
    .last_word   (in_last_word),
    .view        (view)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_code_r <= 8'd2;
      fin_code_r  <= 8'd4;
      syn_code_r  <= 8'd0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DATA_TYPE: data_code_r <= cfg_wdata;
        CFG_FIN_TYPE:  fin_code_r  <= cfg_wdata;
        CFG_SYN_TYPE:  syn_code_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // verdict
  always_comb begin
    res_action    = ACT_DROP;
    res_ack       = '0;
    exp_seq_nxt   = exp_seq_r;
    link_open_nxt = link_open_r;
    priority if (!link_open_r) begin
      res_action = ACT_CLOSED;
    end else if (view.pkt_type == data_code_r && view.checksum_ok) begin
      if (view.seq == exp_seq_r) begin
        res_action  = ACT_ACCEPT;
        res_ack     = exp_seq_r;
        exp_seq_nxt = exp_seq_r + 8'd1;
      end else begin
        res_action = ACT_DUP;
        res_ack    = exp_seq_r - 8'd1;
      end
    end else if (view.pkt_type == fin_code_r) begin
      res_action    = ACT_FIN;
      link_open_nxt = 1'b0;
    end else if (view.pkt_type == syn_code_r) begin
      res_action = ACT_RESET;
      res_ack    = exp_seq_r;
    end else begin
      res_action = ACT_DROP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_seq_r   <= '0;
      link_open_r <= 1'b1;
    end else if (fire) begin
      exp_seq_r   <= exp_seq_nxt;
      link_open_r <= link_open_nxt;
    end
  end

  // result register with skid stage
  assign drain = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (drain) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (fire) begin
      if (drain) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (drain) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (drain) begin
        out_action_r <= skid_action_r;
        out_ack_r    <= skid_ack_r;
        out_ok_r     <= skid_ok_r;
      end
    end else if (fire) begin
      if (drain) begin
        out_action_r <= res_action;
        out_ack_r    <= res_ack;
        out_ok_r     <= view.checksum_ok;
      end else begin
        skid_action_r <= res_action;
        skid_ack_r    <= res_ack;
        skid_ok_r     <= view.checksum_ok;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = out_action_r;
  assign out_ack_seq     = out_ack_r;
  assign out_checksum_ok = out_ok_r;

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while result register empty");

  a_link_stays_closed: assert property (@(posedge clk) disable iff (!rst_n)
    !link_open_r |=> !link_open_r)
    else $error("link reopened without reset");

  a_seq_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_action == ACT_ACCEPT) |=> exp_seq_r == 8'($past(exp_seq_r) + 8'd1))
    else $error("expected sequence did not advance on accept");

  a_seq_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(exp_seq_r))
    else $error("expected sequence moved without a verdict");
`endif

endmodule

>>> hdl/gbnrc_acc.sv
// Checksum accumulator and held header registers.
module gbnrc_acc import gbnrc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              req_type,
  input  logic [TYPE_W-1:0] pkt_type,
  input  logic [SEQ_W-1:0]  rx_seq,
  input  logic [CSUM_W-1:0] rx_checksum,
  input  logic [CSUM_W-1:0] data_word,
  input  logic              last_word,
  output hdr_view_t         view
);

  logic [CSUM_W-1:0] sum_r,  sum_nxt;
  logic [TYPE_W-1:0] type_r, type_nxt;
  logic [SEQ_W-1:0]  seq_r,  seq_nxt;
  logic [CSUM_W-1:0] chk_r,  chk_nxt;
  logic [CSUM_W-1:0] addend;
  logic [CSUM_W-1:0] base;
  logic [CSUM_W:0]   raw;

  always_comb begin
    if (req_kind_t'(req_type) == REQ_HEADER) begin
      type_nxt = pkt_type;
      seq_nxt  = rx_seq;
      chk_nxt  = rx_checksum;
      addend   = {rx_seq, pkt_type};
      base     = '0;
    end else begin
      type_nxt = type_r;
      seq_nxt  = seq_r;
      chk_nxt  = chk_r;
      addend   = data_word;
      base     = sum_r;
    end
    // end-around carry
    raw     = {1'b0, base} + {1'b0, addend};
    sum_nxt = raw[CSUM_W-1:0] + {{(CSUM_W-1){1'b0}}, raw[CSUM_W]};
    view.pkt_type    = type_nxt;
    view.seq         = seq_nxt;
    view.checksum_ok = (~sum_nxt) == chk_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      type_r <= '0;
      seq_r  <= '0;
      chk_r  <= '0;
    end else if (accept) begin
      if (last_word) begin
        sum_r  <= '0;
        type_r <= '0;
        seq_r  <= '0;
        chk_r  <= '0;
      end else begin
        sum_r  <= sum_nxt;
        type_r <= type_nxt;
        seq_r  <= seq_nxt;
        chk_r  <= chk_nxt;
      end
    end
  end

endmodule
